@@ hw/rtl/awrs_pkg.sv @@
// ----------------------------------------------------------------------------
// awrs_pkg
// Shared constants, types and helpers of the accelerometer window framer.
// ----------------------------------------------------------------------------
package awrs_pkg;

  localparam int MAX_WINDOW = 1024;
  localparam int WS_W       = 11;
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W      = 16 + $clog2(MAX_WINDOW);
  localparam int SQ_W       = 31 + $clog2(MAX_WINDOW);
  localparam int V_W        = SQ_W + CNT_W;
  localparam int M_W        = 2 * CNT_W;
  localparam int ROOT_W     = 32;
  localparam int Q_W        = 64;
  localparam int DIV_STEPS  = V_W + 32;
  localparam int STEP_W     = $clog2(DIV_STEPS + 1);
  localparam int NUM_AXES   = 3;

  localparam logic [7:0] HDR_RAW_ALL  = 8'hAA;
  localparam logic [7:0] HDR_RAW_ALL2 = 8'h55;
  localparam logic [7:0] HDR_RAW_ONE  = 8'hAB;
  localparam logic [7:0] HDR_ST_ALL   = 8'hBA;
  localparam logic [7:0] HDR_ST_ALL2  = 8'h56;
  localparam logic [7:0] HDR_ST_ONE   = 8'hBB;

  localparam logic [2:0] REG_RAW_MODE = 3'd0;
  localparam logic [2:0] REG_ALL_AXES = 3'd1;
  localparam logic [2:0] REG_SEL_AXIS = 3'd2;
  localparam logic [2:0] REG_WINDOW   = 3'd3;
  localparam logic [2:0] REG_BIAS_X   = 3'd4;
  localparam logic [2:0] REG_BIAS_Y   = 3'd5;
  localparam logic [2:0] REG_BIAS_Z   = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQUARE, ST_ACC, ST_RAW, ST_HDR, ST_PREP, ST_START, ST_CALC, ST_VAL
  } frm_state_t;

  typedef enum logic [1:0] {
    PH_IDLE, PH_MUL, PH_DIV, PH_ROOT
  } sqrt_phase_t;

  typedef struct packed {
    logic load;
    logic square;
    logic acc;
    logic clear;
  } lane_ctrl_t;

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    if (v > 17'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -17'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

endpackage

@@ hw/rtl/accel_window_rms_std_framer.sv @@
// ----------------------------------------------------------------------------
// accel_window_rms_std_framer
// Three-axis sample framer: raw byte stream or per-window RMS / std packets.
// ----------------------------------------------------------------------------
// Input channel in_*: one three-axis sample per transaction. Output channel
// out_*: one packet byte per transaction, out_last_byte marks the final byte
// of a packet. Configuration cfg_*: write enable, register index and data,
// taken on any clock edge with cfg_we; the user must write only while the block is idle, the block does not enforce it.
// Three axis lanes run side by side (bias, saturation, squaring,
// accumulation); the framer merges their results into bytes.
// A sample is taken only when the block is idle. A statistics sample that
// does not close a window frees the input after the square and acc states.
// A raw sample produces 2 to 8 bytes, one byte per cycle while out_ready
// is high; the first byte shows after the square, acc and raw states.
// At a window end in statistics mode each of the 2 or 6 values runs through
// the shared square-root unit (prep, start, then multiply, divide and root
// phases) and then goes out as 4 bytes.
// A stalled receiver holds the output register and the framer waits; no
// byte is dropped. Reset clears sums, sample count and the registers to
// their defaults (raw mode, all axes, x, 1000 samples, zero bias).
// ----------------------------------------------------------------------------
module accel_window_rms_std_framer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [15:0]             in_accel_x,
  input  logic signed [15:0]             in_accel_y,
  input  logic signed [15:0]             in_accel_z,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_byte,
  output logic                           out_last_byte,
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_index,
  input  logic [15:0]                    cfg_wdata
);
  import awrs_pkg::*;

  // configuration
  logic              raw_mode_r, all_axes_r;
  logic [1:0]        sel_axis_r;
  logic [WS_W-1:0]   window_r;
  logic signed [15:0] bias_r [NUM_AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_mode_r <= 1'b1;
      all_axes_r <= 1'b1;
      sel_axis_r <= 2'd0;
      window_r   <= WS_W'(1000);
      bias_r[0]  <= '0;
      bias_r[1]  <= '0;
      bias_r[2]  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RAW_MODE: raw_mode_r <= cfg_wdata[0];
        REG_ALL_AXES: all_axes_r <= cfg_wdata[0];
        REG_SEL_AXIS: sel_axis_r <= cfg_wdata[1:0];
        REG_WINDOW:   window_r   <= cfg_wdata[WS_W-1:0];
        REG_BIAS_X:   bias_r[0]  <= cfg_wdata;
        REG_BIAS_Y:   bias_r[1]  <= cfg_wdata;
        REG_BIAS_Z:   bias_r[2]  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [1:0]       axis;
  logic [CNT_W-1:0] w_eff;
  assign axis = (sel_axis_r == 2'd3) ? 2'd2 : sel_axis_r;

  always_comb begin
    if (window_r == '0) begin
      w_eff = CNT_W'(1);
    end else if (int'(window_r) > MAX_WINDOW) begin
      w_eff = CNT_W'(MAX_WINDOW);
    end else begin
      w_eff = CNT_W'(window_r);
    end
  end

  // framer state
  frm_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, cnt_r;
  logic [CNT_W-1:0] cnt_acc;
  logic             end_r, hdr_r;
  logic [2:0]       bcnt_r;
  logic [2:0]       vidx_r;
  logic             in_acc;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign cnt_acc  = count_r + 1'b1;

  // lanes
  lane_ctrl_t        lctrl;
  logic signed [15:0] samp [NUM_AXES];
  logic signed [15:0] lval [NUM_AXES];
  logic signed [SUM_W-1:0] lsum [NUM_AXES];
  logic [SQ_W-1:0]   lsq  [NUM_AXES];

  assign samp[0] = in_accel_x;
  assign samp[1] = in_accel_y;
  assign samp[2] = in_accel_z;

  assign lctrl.load   = in_acc;
  assign lctrl.square = (state_r == ST_SQUARE);
  assign lctrl.acc    = (state_r == ST_ACC);
  assign lctrl.clear  = end_r;

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    awrs_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (lctrl),
      .sample   (samp[g]),
      .bias     (bias_r[g]),
      .value    (lval[g]),
      .snap_sum (lsum[g]),
      .snap_sq  (lsq[g])
    );
  end

  // value selection for statistics
  logic             is_std, last_val;
  logic [1:0]       vax;
  logic [SUM_W-1:0] mag;
  logic [V_W-1:0]   mag_sq;
  logic [M_W-1:0]   cnt_sq;
  logic [V_W-1:0]   sub_r;
  logic [M_W-1:0]   m_r;
  logic             sq_start, sq_busy, sq_done;
  logic [ROOT_W-1:0] sq_root;

  always_comb begin
    if (all_axes_r) begin
      is_std   = (vidx_r >= 3'd3);
      vax      = is_std ? 2'(vidx_r - 3'd3) : vidx_r[1:0];
      last_val = (vidx_r == 3'd5);
    end else begin
      is_std   = (vidx_r == 3'd1);
      vax      = axis;
      last_val = (vidx_r == 3'd1);
    end
  end

  assign mag    = lsum[vax][SUM_W-1] ? SUM_W'(-lsum[vax]) : SUM_W'(lsum[vax]);
  assign mag_sq = mag * mag;
  assign cnt_sq = cnt_r * cnt_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_PREP) begin
      sub_r <= is_std ? mag_sq : '0;
      m_r   <= is_std ? cnt_sq : M_W'(cnt_r);
    end
  end

  awrs_qsqrt u_qsqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .mul_a (is_std ? cnt_r : CNT_W'(1)),
    .val   (lsq[vax]),
    .sub   (sub_r),
    .m     (m_r),
    .busy  (sq_busy),
    .done  (sq_done),
    .root  (sq_root)
  );

  // output register
  logic       out_valid_r, out_last_r;
  logic [7:0] out_byte_r;
  logic       emit, emit_last, load;
  logic [7:0] emit_byte;
  logic [2:0] raw_n, d;
  logic [1:0] rax;
  logic       raw_end, hdr_end, val_end;

  assign load    = emit && (!out_valid_r || out_ready);
  assign raw_n   = (hdr_r ? 3'd2 : 3'd0) + (all_axes_r ? 3'd6 : 3'd2);
  assign d       = bcnt_r - (hdr_r ? 3'd2 : 3'd0);
  assign rax     = all_axes_r ? d[2:1] : axis;
  assign raw_end = (bcnt_r == raw_n - 3'd1);
  assign hdr_end = (bcnt_r == 3'd1);
  assign val_end = (bcnt_r == 3'd3);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = ST_SQUARE;
      ST_SQUARE: state_nxt = ST_ACC;
      ST_ACC: begin
        if (raw_mode_r) begin
          state_nxt = ST_RAW;
        end else if (end_r) begin
          state_nxt = ST_HDR;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RAW:   if (load && raw_end) state_nxt = ST_IDLE;
      ST_HDR:   if (load && hdr_end) state_nxt = ST_PREP;
      ST_PREP:  state_nxt = ST_START;
      ST_START: state_nxt = ST_CALC;
      ST_CALC:  if (sq_done) state_nxt = ST_VAL;
      ST_VAL: begin
        if (load && val_end) begin
          state_nxt = last_val ? ST_IDLE : ST_PREP;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    emit      = 1'b0;
    emit_byte = '0;
    emit_last = 1'b0;
    sq_start  = 1'b0;
    unique case (state_r)
      ST_RAW: begin
        emit      = 1'b1;
        emit_last = end_r && raw_end;
        if (hdr_r && bcnt_r == 3'd0) begin
          emit_byte = all_axes_r ? HDR_RAW_ALL : HDR_RAW_ONE;
        end else if (hdr_r && bcnt_r == 3'd1) begin
          emit_byte = all_axes_r ? HDR_RAW_ALL2 : {6'd0, axis};
        end else begin
          emit_byte = d[0] ? lval[rax][15:8] : lval[rax][7:0];
        end
      end
      ST_HDR: begin
        emit = 1'b1;
        if (bcnt_r == 3'd0) begin
          emit_byte = all_axes_r ? HDR_ST_ALL : HDR_ST_ONE;
        end else begin
          emit_byte = all_axes_r ? HDR_ST_ALL2 : {6'd0, axis};
        end
      end
      ST_START: sq_start = 1'b1;
      ST_VAL: begin
        emit      = 1'b1;
        emit_byte = sq_root[8*bcnt_r[1:0] +: 8];
        emit_last = last_val && val_end;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      bcnt_r      <= '0;
      vidx_r      <= '0;
      end_r       <= 1'b0;
      hdr_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        hdr_r  <= (count_r == '0);
        cnt_r  <= cnt_acc;
        end_r  <= (cnt_acc >= w_eff);
        bcnt_r <= '0;
        vidx_r <= '0;
        count_r <= (cnt_acc >= w_eff) ? '0 : cnt_acc;
      end
      if (load) begin
        if ((state_r == ST_HDR && hdr_end) || (state_r == ST_VAL && val_end)) begin
          bcnt_r <= '0;
        end else begin
          bcnt_r <= bcnt_r + 1'b1;
        end
        if (state_r == ST_VAL && val_end) begin
          vidx_r <= vidx_r + 1'b1;
        end
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= emit_byte;
      out_last_r <= emit_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last_byte = out_last_r;

  // checks
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("sample taken while another is in flight");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sq_start |-> !sq_busy)
    else $error("square-root unit restarted while busy");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) < MAX_WINDOW)
    else $error("sample count beyond window limit");

  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> !in_ready)
    else $error("byte emitted while input open");

endmodule

@@ hw/rtl/awrs_lane.sv @@
// ----------------------------------------------------------------------------
// awrs_lane
// One axis: bias removal with saturation, squaring and window accumulation.
// ----------------------------------------------------------------------------
module awrs_lane (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  awrs_pkg::lane_ctrl_t                 ctrl,
  input  logic signed [15:0]                   sample,
  input  logic signed [15:0]                   bias,
  output logic signed [15:0]                   value,
  output logic signed [awrs_pkg::SUM_W-1:0]    snap_sum,
  output logic        [awrs_pkg::SQ_W-1:0]     snap_sq
);
  import awrs_pkg::*;

  logic signed [15:0]      v_r;
  logic        [30:0]      sq_r;
  logic signed [31:0]      prod;
  logic signed [16:0]      diff;
  logic signed [SUM_W-1:0] sum_r, sum_nxt, snap_sum_r;
  logic        [SQ_W-1:0]  sqs_r, sqs_nxt, snap_sq_r;

  assign diff    = {sample[15], sample} - {bias[15], bias};
  assign prod    = v_r * v_r;
  assign sum_nxt = sum_r + SUM_W'(v_r);
  assign sqs_nxt = sqs_r + SQ_W'(sq_r);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      v_r <= sat16(diff);
    end
    if (ctrl.square) begin
      sq_r <= prod[30:0];
    end
    if (ctrl.acc && ctrl.clear) begin
      snap_sum_r <= sum_nxt;
      snap_sq_r  <= sqs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      sqs_r <= '0;
    end else if (ctrl.acc) begin
      if (ctrl.clear) begin
        sum_r <= '0;
        sqs_r <= '0;
      end else begin
        sum_r <= sum_nxt;
        sqs_r <= sqs_nxt;
      end
    end
  end

  assign value    = v_r;
  assign snap_sum = snap_sum_r;
  assign snap_sq  = snap_sq_r;

endmodule

@@ hw/rtl/awrs_qsqrt.sv @@
// ----------------------------------------------------------------------------
// awrs_qsqrt
// Shared unit: floor(sqrt((a*val - sub) * 2^32 / m)) by serial multiply,
// restoring division and digit-by-digit square root.
// ----------------------------------------------------------------------------
module awrs_qsqrt (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [awrs_pkg::CNT_W-1:0]         mul_a,
  input  logic [awrs_pkg::SQ_W-1:0]          val,
  input  logic [awrs_pkg::V_W-1:0]           sub,
  input  logic [awrs_pkg::M_W-1:0]           m,
  output logic                               busy,
  output logic                               done,
  output logic [awrs_pkg::ROOT_W-1:0]        root
);
  import awrs_pkg::*;

  localparam int X_W = V_W + 32;

  sqrt_phase_t ph_r, ph_nxt;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  a_r;
  logic [SQ_W-1:0]   val_r;
  logic [V_W-1:0]    sub_r;
  logic [M_W-1:0]    m_r;
  logic [V_W-1:0]    prod_r;
  logic [X_W-1:0]    dvd_r;
  logic [M_W-1:0]    rem_r;
  logic [Q_W-1:0]    q_r;
  logic [34:0]       srem_r;
  logic [ROOT_W-1:0] root_r;
  logic              done_r;

  logic [M_W:0]      dtrial;
  logic [34:0]       sshift;
  logic [34:0]       strial;
  logic [V_W-1:0]    prod_nxt;
  logic              last_step;

  assign prod_nxt  = {prod_r[V_W-2:0], 1'b0} + (a_r[CNT_W-1] ? V_W'(val_r) : '0);
  assign dtrial    = {rem_r, dvd_r[X_W-1]};
  assign sshift    = {srem_r[32:0], q_r[Q_W-1:Q_W-2]};
  assign strial    = 35'({root_r, 2'b01});

  always_comb begin
    last_step = 1'b0;
    unique case (ph_r)
      PH_MUL:  last_step = (step_r == STEP_W'(CNT_W - 1));
      PH_DIV:  last_step = (step_r == STEP_W'(DIV_STEPS - 1));
      PH_ROOT: last_step = (step_r == STEP_W'(ROOT_W - 1));
      default: last_step = 1'b0;
    endcase
  end

  always_comb begin
    ph_nxt = ph_r;
    unique case (ph_r)
      PH_IDLE: if (start) ph_nxt = PH_MUL;
      PH_MUL:  if (last_step) ph_nxt = PH_DIV;
      PH_DIV:  if (last_step) ph_nxt = PH_ROOT;
      PH_ROOT: if (last_step) ph_nxt = PH_IDLE;
      default: ph_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= (ph_r == PH_ROOT) && last_step;
      if (ph_r == PH_IDLE || last_step) begin
        step_r <= '0;
      end else begin
        step_r <= step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ph_r)
      PH_IDLE: begin
        if (start) begin
          a_r    <= mul_a;
          val_r  <= val;
          sub_r  <= sub;
          m_r    <= m;
          prod_r <= '0;
        end
      end
      PH_MUL: begin
        prod_r <= prod_nxt;
        a_r    <= {a_r[CNT_W-2:0], 1'b0};
        if (last_step) begin
          dvd_r <= {prod_nxt - sub_r, 32'h0};
          rem_r <= '0;
          q_r   <= '0;
        end
      end
      PH_DIV: begin
        dvd_r <= {dvd_r[X_W-2:0], 1'b0};
        if (dtrial >= {1'b0, m_r}) begin
          rem_r <= M_W'(dtrial - {1'b0, m_r});
          q_r   <= {q_r[Q_W-2:0], 1'b1};
        end else begin
          rem_r <= dtrial[M_W-1:0];
          q_r   <= {q_r[Q_W-2:0], 1'b0};
        end
        if (last_step) begin
          srem_r <= '0;
          root_r <= '0;
        end
      end
      PH_ROOT: begin
        q_r <= {q_r[Q_W-3:0], 2'b00};
        // bring down two bits, keep the root bit when the trial fits
        if (sshift >= strial) begin
          srem_r <= sshift - strial;
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          srem_r <= sshift;
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  assign busy = (ph_r != PH_IDLE);
  assign done = done_r;
  assign root = root_r;

endmodule
